// ===== rtl/rft_pkg.sv =====
package rft_pkg;

    // Field widths
    localparam int VEL_W    = 16;   // signed Q4.12 velocities and setpoints
    localparam int GAIN_W   = 16;   // unsigned Q0.16 gains
    localparam int EFFORT_W = 32;   // signed Q16.16 efforts
    localparam int MASK_W   = 4;
    localparam int NUM_AXES = 4;
    localparam int CFG_IDX_W = 2;

    // Internal widths
    localparam int ABS_W   = VEL_W;            // |x| of a Q4.12 value, up to 2^15
    localparam int PROD_W  = 2 * VEL_W - 1;    // |a*b| <= 2^30
    localparam int SQ_W    = 2 * PROD_W;       // (a*b)^2 at scale 2^-48
    localparam int POLY_W  = 63;               // polynomial sum stays below 2^63
    localparam int P16_W   = POLY_W - 32;      // polynomial in Q.16
    localparam int ERR_W   = VEL_W + 1;        // velocity error, Q5.12
    localparam int AE_W    = VEL_W;            // |error| <= 65535
    localparam int GE_W    = AE_W + GAIN_W;
    localparam int MAG_W   = GE_W + P16_W;     // full magnitude product
    localparam int MAG_SHIFT = 28;

    localparam logic [POLY_W-1:0] POLY_ONE = POLY_W'(1) << 48;
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(655);

    localparam logic signed [EFFORT_W-1:0] EFFORT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [EFFORT_W-1:0] EFFORT_MIN = 32'sh8000_0000;

    // Axis lanes, also the bit positions of the disable mask
    localparam int AX_SURGE = 0;
    localparam int AX_SWAY  = 1;
    localparam int AX_HEAVE = 2;
    localparam int AX_YAW   = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_SURGE = 2'd0,
        REG_GAIN_SWAY  = 2'd1,
        REG_GAIN_HEAVE = 2'd2,
        REG_GAIN_YAW   = 2'd3
    } cfg_reg_t;

    // Magnitude of a signed Q4.12 value; -32768 maps to 32768
    function automatic logic [ABS_W-1:0] abs_vel(input logic signed [VEL_W-1:0] x);
        logic [ABS_W-1:0] neg;
        neg = ABS_W'(-x);
        return x[VEL_W-1] ? neg : ABS_W'(x);
    endfunction

endpackage

// ===== rtl/robustifying_force_terms_top.sv =====
// Robustifying force terms: per word, four efforts -gain * (vel - setpoint) * poly(velocities),
// saturated to signed Q16.16, with disabled axes forced to zero. Fully pipelined: a new word
// may be started in every cycle and busy stays low; each result appears with done high for one
// cycle, once its word has passed the pipeline. The pipeline holds a chain of three pipelined
// multiplies (velocity products, their squares, gain times polynomial) and the two-stage
// polynomial adder. The receiver cannot stall, so results are never held back. Gains are
// written through the cfg channel, which is always ready.
module robustifying_force_terms_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // command channel
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [rft_pkg::VEL_W-1:0]       vel_surge,
    input  logic signed [rft_pkg::VEL_W-1:0]       vel_sway,
    input  logic signed [rft_pkg::VEL_W-1:0]       vel_heave,
    input  logic signed [rft_pkg::VEL_W-1:0]       rate_roll,
    input  logic signed [rft_pkg::VEL_W-1:0]       rate_pitch,
    input  logic signed [rft_pkg::VEL_W-1:0]       rate_yaw,
    input  logic signed [rft_pkg::VEL_W-1:0]       target_surge,
    input  logic signed [rft_pkg::VEL_W-1:0]       target_sway,
    input  logic signed [rft_pkg::VEL_W-1:0]       target_heave,
    input  logic signed [rft_pkg::VEL_W-1:0]       target_yaw,
    input  logic        [rft_pkg::MASK_W-1:0]      axis_disable_mask,
    // result
    output logic                                   done,
    output logic signed [rft_pkg::EFFORT_W-1:0]    effort_surge,
    output logic signed [rft_pkg::EFFORT_W-1:0]    effort_sway,
    output logic signed [rft_pkg::EFFORT_W-1:0]    effort_heave,
    output logic signed [rft_pkg::EFFORT_W-1:0]    effort_yaw,
    // configuration
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic        [rft_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic        [rft_pkg::GAIN_W-1:0]      cfg_data
);
    import rft_pkg::*;

    // Velocity product lanes
    localparam int P_VR = 0;
    localparam int P_WQ = 1;
    localparam int P_PR = 2;
    localparam int P_UR = 3;
    localparam int P_WP = 4;
    localparam int P_QR = 5;
    localparam int P_UQ = 6;
    localparam int P_VP = 7;
    localparam int P_UU = 8;
    localparam int P_VV = 9;
    localparam int P_WW = 10;
    localparam int P_PP = 11;
    localparam int P_QQ = 12;
    localparam int P_RR = 13;
    localparam int NUM_PROD = 14;

    // Gain registers
    logic [GAIN_W-1:0] gain_reg [NUM_AXES];

    // Pipeline valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    // Stage payloads
    logic [PROD_W-1:0]   prod1_reg  [NUM_PROD];
    logic [AE_W-1:0]     ae1_reg    [NUM_AXES];
    logic [NUM_AXES-1:0] eneg1_reg, eneg2_reg, eneg3_reg, eneg4_reg, eneg5_reg;
    logic [MASK_W-1:0]   mask1_reg, mask2_reg, mask3_reg, mask4_reg, mask5_reg;

    logic [SQ_W-1:0]     sq2_reg    [NUM_PROD];
    logic [PROD_W-1:0]   self2_reg  [NUM_AXES];
    logic [GE_W-1:0]     ge2_reg    [NUM_AXES];

    logic [POLY_W-1:0]   cross3_reg [NUM_AXES];
    logic [POLY_W-1:0]   self3_reg  [NUM_AXES];
    logic [GE_W-1:0]     ge3_reg    [NUM_AXES];

    logic [P16_W-1:0]    p16_4_reg  [NUM_AXES];
    logic [GE_W-1:0]     ge4_reg    [NUM_AXES];

    logic [MAG_W-1:0]    mag5_reg   [NUM_AXES];

    logic signed [EFFORT_W-1:0] eff6_reg [NUM_AXES];

    // Combinational next values
    logic [ABS_W-1:0]    au, av, aw, ap, aq, ar;
    logic signed [ERR_W-1:0] err [NUM_AXES];
    logic [PROD_W-1:0]   prod1_next [NUM_PROD];
    logic [AE_W-1:0]     ae1_next   [NUM_AXES];
    logic [NUM_AXES-1:0] eneg1_next;
    logic [POLY_W-1:0]   cross3_next [NUM_AXES];
    logic [POLY_W-1:0]   self3_next  [NUM_AXES];
    logic [POLY_W-1:0]   poly4      [NUM_AXES];
    logic signed [EFFORT_W-1:0] eff6_next [NUM_AXES];

    // Fully pipelined, never stalls
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Gain register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                gain_reg[i] <= GAIN_RESET;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GAIN_SURGE: gain_reg[AX_SURGE] <= cfg_data;
                REG_GAIN_SWAY:  gain_reg[AX_SWAY]  <= cfg_data;
                REG_GAIN_HEAVE: gain_reg[AX_HEAVE] <= cfg_data;
                REG_GAIN_YAW:   gain_reg[AX_YAW]   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 1: magnitudes, pairwise velocity products, velocity errors
    always_comb
    begin
        au = abs_vel(vel_surge);
        av = abs_vel(vel_sway);
        aw = abs_vel(vel_heave);
        ap = abs_vel(rate_roll);
        aq = abs_vel(rate_pitch);
        ar = abs_vel(rate_yaw);

        prod1_next[P_VR] = PROD_W'(av * ar);
        prod1_next[P_WQ] = PROD_W'(aw * aq);
        prod1_next[P_PR] = PROD_W'(ap * ar);
        prod1_next[P_UR] = PROD_W'(au * ar);
        prod1_next[P_WP] = PROD_W'(aw * ap);
        prod1_next[P_QR] = PROD_W'(aq * ar);
        prod1_next[P_UQ] = PROD_W'(au * aq);
        prod1_next[P_VP] = PROD_W'(av * ap);
        prod1_next[P_UU] = PROD_W'(au * au);
        prod1_next[P_VV] = PROD_W'(av * av);
        prod1_next[P_WW] = PROD_W'(aw * aw);
        prod1_next[P_PP] = PROD_W'(ap * ap);
        prod1_next[P_QQ] = PROD_W'(aq * aq);
        prod1_next[P_RR] = PROD_W'(ar * ar);

        err[AX_SURGE] = ERR_W'(vel_surge) - ERR_W'(target_surge);
        err[AX_SWAY]  = ERR_W'(vel_sway)  - ERR_W'(target_sway);
        err[AX_HEAVE] = ERR_W'(vel_heave) - ERR_W'(target_heave);
        err[AX_YAW]   = ERR_W'(rate_yaw)  - ERR_W'(target_yaw);

        for (int i = 0; i < NUM_AXES; i++)
        begin
            eneg1_next[i] = err[i][ERR_W-1];
            ae1_next[i]   = err[i][ERR_W-1] ? AE_W'(-err[i]) : AE_W'(err[i]);
        end
    end

    // Stage 3: cross terms and self terms of each polynomial
    always_comb
    begin
        cross3_next[AX_SURGE] = POLY_W'(sq2_reg[P_VR]) + POLY_W'(sq2_reg[P_WQ])
                              + POLY_W'(sq2_reg[P_PR]);
        cross3_next[AX_SWAY]  = POLY_W'(sq2_reg[P_UR]) + POLY_W'(sq2_reg[P_WP])
                              + POLY_W'(sq2_reg[P_QR]);
        cross3_next[AX_HEAVE] = POLY_W'(sq2_reg[P_UQ]) + POLY_W'(sq2_reg[P_VP])
                              + POLY_W'(sq2_reg[P_PP]) + POLY_W'(sq2_reg[P_QQ]);
        cross3_next[AX_YAW]   = '0;

        // 1 + x^2 + x^4 at scale 2^-48 (yaw has no constant)
        self3_next[AX_SURGE] = POLY_ONE + (POLY_W'(self2_reg[AX_SURGE]) << 24)
                             + POLY_W'(sq2_reg[P_UU]);
        self3_next[AX_SWAY]  = POLY_ONE + (POLY_W'(self2_reg[AX_SWAY]) << 24)
                             + POLY_W'(sq2_reg[P_VV]);
        self3_next[AX_HEAVE] = POLY_ONE + (POLY_W'(self2_reg[AX_HEAVE]) << 24)
                             + POLY_W'(sq2_reg[P_WW]);
        self3_next[AX_YAW]   = (POLY_W'(self2_reg[AX_YAW]) << 24)
                             + POLY_W'(sq2_reg[P_RR]);
    end

    // Stage 4: full polynomial, truncated to Q.16
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            poly4[i] = cross3_reg[i] + self3_reg[i];
        end
    end

    // Stage 6: scale, saturate, apply sign and disable mask
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            logic sat;
            logic [EFFORT_W-1:0] mag;
            sat = |mag5_reg[i][MAG_W-1:MAG_SHIFT+EFFORT_W-1];
            mag = {1'b0, mag5_reg[i][MAG_SHIFT+EFFORT_W-2:MAG_SHIFT]};
            if (mask5_reg[i])
            begin
                eff6_next[i] = '0;
            end
            else if (eneg5_reg[i])
            begin
                eff6_next[i] = sat ? EFFORT_MAX : signed'(mag);
            end
            else
            begin
                eff6_next[i] = sat ? EFFORT_MIN : signed'(-mag);
            end
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // Data path registers
    always_ff @(posedge clk)
    begin
        // stage 1
        prod1_reg <= prod1_next;
        ae1_reg   <= ae1_next;
        eneg1_reg <= eneg1_next;
        mask1_reg <= axis_disable_mask;

        // stage 2: squares of products, error times gain
        for (int k = 0; k < NUM_PROD; k++)
        begin
            sq2_reg[k] <= SQ_W'(prod1_reg[k] * prod1_reg[k]);
        end
        self2_reg[AX_SURGE] <= prod1_reg[P_UU];
        self2_reg[AX_SWAY]  <= prod1_reg[P_VV];
        self2_reg[AX_HEAVE] <= prod1_reg[P_WW];
        self2_reg[AX_YAW]   <= prod1_reg[P_RR];
        for (int i = 0; i < NUM_AXES; i++)
        begin
            ge2_reg[i] <= GE_W'(ae1_reg[i] * gain_reg[i]);
        end
        eneg2_reg <= eneg1_reg;
        mask2_reg <= mask1_reg;

        // stage 3
        cross3_reg <= cross3_next;
        self3_reg  <= self3_next;
        ge3_reg    <= ge2_reg;
        eneg3_reg  <= eneg2_reg;
        mask3_reg  <= mask2_reg;

        // stage 4
        for (int i = 0; i < NUM_AXES; i++)
        begin
            p16_4_reg[i] <= poly4[i][POLY_W-1:32];
        end
        ge4_reg   <= ge3_reg;
        eneg4_reg <= eneg3_reg;
        mask4_reg <= mask3_reg;

        // stage 5: magnitude product
        for (int i = 0; i < NUM_AXES; i++)
        begin
            mag5_reg[i] <= MAG_W'(ge4_reg[i] * p16_4_reg[i]);
        end
        eneg5_reg <= eneg4_reg;
        mask5_reg <= mask4_reg;

        // stage 6: output register
        eff6_reg <= eff6_next;
    end

    assign done         = v6_reg;
    assign effort_surge = eff6_reg[AX_SURGE];
    assign effort_sway  = eff6_reg[AX_SWAY];
    assign effort_heave = eff6_reg[AX_HEAVE];
    assign effort_yaw   = eff6_reg[AX_YAW];

endmodule

// ===== tb/tb_robustifying_force_terms_top.sv =====
`timescale 1ns / 1ps

module tb_robustifying_force_terms_top;
    import rft_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 20;   // longer than the pipeline

    // One command word as it sits on the input ports
    typedef struct packed {
        logic signed [VEL_W-1:0] u, v, w, p, q, r;
        logic signed [VEL_W-1:0] su, sv, sw, sr;
        logic [MASK_W-1:0] mask;
    } motion_word_t;

    typedef struct packed {
        logic signed [EFFORT_W-1:0] surge, sway, heave, yaw;
    } effort_set_t;

    typedef logic [NUM_AXES-1:0][GAIN_W-1:0] gain_set_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    motion_word_t stim;
    logic done;
    logic signed [EFFORT_W-1:0] effort_surge, effort_sway, effort_heave, effort_yaw;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [GAIN_W-1:0] cfg_data;

    // Gains as the block should hold them
    logic [GAIN_W-1:0] gain_now [NUM_AXES];
    effort_set_t expected_efforts [$];
    effort_set_t oldest_effort;
    int mismatches = 0;
    int sender_idle_pct = 0;
    int cycle_count = 0;

    robustifying_force_terms_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .vel_surge         (stim.u),
        .vel_sway          (stim.v),
        .vel_heave         (stim.w),
        .rate_roll         (stim.p),
        .rate_pitch        (stim.q),
        .rate_yaw          (stim.r),
        .target_surge      (stim.su),
        .target_sway       (stim.sv),
        .target_heave      (stim.sw),
        .target_yaw        (stim.sr),
        .axis_disable_mask (stim.mask),
        .done              (done),
        .effort_surge      (effort_surge),
        .effort_sway       (effort_sway),
        .effort_heave      (effort_heave),
        .effort_yaw        (effort_yaw),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Force-term predictor
    // ------------------------------------------------------------------

    // (a*b)^2 at scale 2^-48
    function automatic logic [63:0] sq_of_prod(longint a, longint b);
        longint x;
        logic [63:0] m;
        x = a * b;
        m = (x < 0) ? -x : x;
        return m * m;
    endfunction

    // a^2 moved up to scale 2^-48
    function automatic logic [63:0] sq_scaled(longint a);
        logic [63:0] m;
        m = (a < 0) ? -a : a;
        return (m * m) << 24;
    endfunction

    // -sign(e) * |e| * gain * P, P the polynomial floored to Q.16, saturated
    function automatic logic signed [EFFORT_W-1:0] axis_effort(longint e,
                                                               logic [GAIN_W-1:0] g,
                                                               logic [63:0] poly);
        logic [63:0] p16, ae, mag, neg;
        logic [127:0] full;
        p16 = poly >> 32;
        if (e == 0 || p16 == 0 || g == 0)
            return '0;
        ae = (e < 0) ? -e : e;
        full = 128'(ae) * 128'(g) * 128'(p16);
        mag = (full > 128'h7FFF_FFFF_FFFF_FFFF) ? (64'd1 << 40) : 64'(full >> MAG_SHIFT);
        if (e > 0)
        begin
            if (mag >= 64'h8000_0000)
                return EFFORT_MIN;
            neg = -mag;
            return neg[EFFORT_W-1:0];
        end
        if (mag > 64'h7FFF_FFFF)
            return EFFORT_MAX;
        return mag[EFFORT_W-1:0];
    endfunction

    function automatic effort_set_t predict_efforts(motion_word_t cmd);
        longint u, v, w, p, q, r;
        logic [63:0] poly_surge, poly_sway, poly_heave, poly_yaw;
        effort_set_t res;
        u = longint'($signed(cmd.u));
        v = longint'($signed(cmd.v));
        w = longint'($signed(cmd.w));
        p = longint'($signed(cmd.p));
        q = longint'($signed(cmd.q));
        r = longint'($signed(cmd.r));
        poly_surge = sq_of_prod(v, r) + sq_of_prod(w, q) + sq_of_prod(p, r) + POLY_ONE
                   + sq_scaled(u) + sq_of_prod(u, u);
        poly_sway  = sq_of_prod(u, r) + sq_of_prod(w, p) + sq_of_prod(q, r) + POLY_ONE
                   + sq_scaled(v) + sq_of_prod(v, v);
        poly_heave = sq_of_prod(u, q) + sq_of_prod(v, p) + sq_of_prod(p, p)
                   + sq_of_prod(q, q) + POLY_ONE + sq_scaled(w) + sq_of_prod(w, w);
        poly_yaw   = sq_scaled(r) + sq_of_prod(r, r);
        res.surge = cmd.mask[AX_SURGE] ? '0 :
            axis_effort(u - longint'($signed(cmd.su)), gain_now[AX_SURGE], poly_surge);
        res.sway  = cmd.mask[AX_SWAY] ? '0 :
            axis_effort(v - longint'($signed(cmd.sv)), gain_now[AX_SWAY], poly_sway);
        res.heave = cmd.mask[AX_HEAVE] ? '0 :
            axis_effort(w - longint'($signed(cmd.sw)), gain_now[AX_HEAVE], poly_heave);
        res.yaw   = cmd.mask[AX_YAW] ? '0 :
            axis_effort(r - longint'($signed(cmd.sr)), gain_now[AX_YAW], poly_yaw);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------

    task automatic check_field(string axis, logic signed [EFFORT_W-1:0] want,
                               logic signed [EFFORT_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: effort_%s mismatch, expected %0d, actual %0d",
                     $time, axis, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_efforts.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d",
                         $time, effort_surge, effort_sway, effort_heave, effort_yaw);
            end
            else
            begin
                oldest_effort = expected_efforts.pop_front();
                check_field("surge", oldest_effort.surge, effort_surge);
                check_field("sway", oldest_effort.sway, effort_sway);
                check_field("heave", oldest_effort.heave, effort_heave);
                check_field("yaw", oldest_effort.yaw, effort_yaw);
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Send one word; start stays high on return, the caller's next step settles it
    task automatic send_word(motion_word_t cmd);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        stim <= cmd;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        expected_efforts = {expected_efforts, predict_efforts(cmd)};
    endtask

    // Hold off the sender until every pending result is back
    task automatic wait_for_drain();
        start <= 1'b0;
        while (expected_efforts.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_gains(gain_set_t gains);
        wait_for_drain();
        for (int i = 0; i < NUM_AXES; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_reg_t'(i);
            cfg_data <= gains[i];
            do @(posedge clk); while (!cfg_ready);
            gain_now[i] = gains[i];
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic motion_word_t pack_word(int u, int v, int w, int p, int q, int r,
                                               int su, int sv, int sw, int sr, int mask);
        motion_word_t cmd;
        cmd.u = VEL_W'(u);
        cmd.v = VEL_W'(v);
        cmd.w = VEL_W'(w);
        cmd.p = VEL_W'(p);
        cmd.q = VEL_W'(q);
        cmd.r = VEL_W'(r);
        cmd.su = VEL_W'(su);
        cmd.sv = VEL_W'(sv);
        cmd.sw = VEL_W'(sw);
        cmd.sr = VEL_W'(sr);
        cmd.mask = MASK_W'(mask);
        return cmd;
    endfunction

    // Half realistic speeds, the rest mostly full-range, some corners
    function automatic logic signed [VEL_W-1:0] rand_speed();
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(4))
                    0: return 16'sh8000;
                    1: return 16'sh7FFF;
                    2: return 16'sh0000;
                    3: return 16'sh0001;
                    default: return 16'shFFFF;
                endcase
            end
            1, 2, 3, 4: return VEL_W'($urandom);
            default: return VEL_W'(int'($urandom_range(16383)) - 8192);
        endcase
    endfunction

    function automatic logic signed [VEL_W-1:0] rand_target(logic signed [VEL_W-1:0] vel);
        return ($urandom_range(99) < 15) ? vel : rand_speed();
    endfunction

    function automatic motion_word_t random_word();
        motion_word_t cmd;
        cmd.u = rand_speed();
        cmd.v = rand_speed();
        cmd.w = rand_speed();
        cmd.p = rand_speed();
        cmd.q = rand_speed();
        cmd.r = rand_speed();
        cmd.su = rand_target(cmd.u);
        cmd.sv = rand_target(cmd.v);
        cmd.sw = rand_target(cmd.w);
        cmd.sr = rand_target(cmd.r);
        cmd.mask = ($urandom_range(99) < 70) ? '0 : MASK_W'($urandom);
        return cmd;
    endfunction

    function automatic gain_set_t pick_gains(int kind);
        gain_set_t gains;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            case (kind)
                0: gains[i] = GAIN_W'($urandom);
                1: gains[i] = '1;
                2: gains[i] = GAIN_W'($urandom_range(2000));
                default: gains[i] = ($urandom_range(3) == 0) ? '0 : GAIN_W'($urandom);
            endcase
        end
        return gains;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset gains: zero input, extremes, zero error, tiny yaw, each disable bit
    task automatic test_reset_gains();
        sender_idle_pct = 35;
        send_word(pack_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(pack_word(32767, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(pack_word(-32768, -32768, -32768, -32768, -32768, -32768,
                            32767, 32767, 32767, 32767, 0));
        send_word(pack_word(32767, 32767, 32767, 32767, 32767, 32767,
                            -32768, -32768, -32768, -32768, 0));
        // setpoints equal the velocities
        send_word(pack_word(12345, -12345, 4096, -777, 777, 9000,
                            12345, -12345, 4096, 9000, 0));
        // yaw polynomial floors to zero for a tiny rate
        send_word(pack_word(100, -100, 50, 3, -3, 1, -20000, 20000, -20000, -20000, 0));
        send_word(pack_word(0, 0, 0, 0, 0, -32768, 0, 0, 0, 32767, 0));
        send_word(pack_word(4096, -4096, 8192, 2048, -2048, 4096, 0, 0, 0, 0, 0));
        for (int b = 0; b < NUM_AXES; b++)
            send_word(pack_word(20000, 20000, 20000, 20000, 20000, 20000,
                                -20000, -20000, -20000, -20000, 1 << b));
        send_word(pack_word(20000, 20000, 20000, 20000, 20000, 20000,
                            -20000, -20000, -20000, -20000, 15));
    endtask

    // Full-scale gains drive saturation; zero gains force zero efforts; then a mixed set
    task automatic test_gain_extremes();
        sender_idle_pct = 35;
        load_gains({NUM_AXES{16'hFFFF}});
        send_word(pack_word(-32768, -32768, -32768, -32768, -32768, -32768,
                            32767, 32767, 32767, 32767, 0));
        send_word(pack_word(32767, 32767, 32767, 32767, 32767, 32767,
                            -32768, -32768, -32768, -32768, 0));
        send_word(pack_word(4096, 4096, 4096, 0, 0, 4096, 0, 0, 0, 0, 0));
        load_gains('0);
        send_word(pack_word(30000, -30000, 30000, -30000, 30000, -30000,
                            -1, 1, -1, 1, 0));
        load_gains({16'd655, 16'd0, 16'hFFFF, 16'd1});
        send_word(pack_word(30000, -30000, 30000, -30000, 30000, -30000,
                            -1, 1, -1, 1, 0));
    endtask

    // Random words in four gain settings per phase
    task automatic test_random_traffic(int idle_pct, int items);
        sender_idle_pct = idle_pct;
        for (int kind = 0; kind < 4; kind++)
        begin
            load_gains(pick_gains(kind));
            repeat (items / 4)
                send_word(random_word());
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        stim <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_GAIN_SURGE;
        cfg_data <= '0;
        for (int i = 0; i < NUM_AXES; i++)
            gain_now[i] = GAIN_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_gains();
        test_gain_extremes();
        test_random_traffic(35, 200);
        test_random_traffic(70, 200);
        test_random_traffic(0, 200);

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
